>>> hdl/pk5_pkg.sv
// ----------------------------------------------------------------------------
// pk5_pkg
// Shared constants, alphabet and queue types of the packed 5-bit text decoder.
// ----------------------------------------------------------------------------
package pk5_pkg;

    localparam int MAX_CHARS   = 255;
    // Room for the count plus the four characters one word can add.
    localparam int CNT_W       = $clog2(MAX_CHARS + 5);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [4:0] CODE_A         = 5'd1;
    localparam logic [4:0] CODE_Z         = 5'd26;
    localparam logic [4:0] CODE_CAP_SPACE = 5'd28;
    localparam logic [4:0] CODE_COMMA     = 5'd29;
    localparam logic [4:0] CODE_PERIOD    = 5'd30;
    localparam logic [4:0] CODE_END       = 5'd31;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [7:0] GLYPHS [32] = '{
        8'h20, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
        8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f,
        8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
        8'h78, 8'h79, 8'h7a, 8'h27, 8'h20, 8'h2c, 8'h2e, 8'h00
    };

    // One result to produce: a decoded code, or an inserted space after it.
    typedef struct packed {
        logic       spc;
        logic [4:0] code;
        logic       endm;
        logic       ovf;
    } t_slot;

    // Work for one accepted word.
    typedef struct packed {
        logic            hdr;
        logic            cap;
        logic [2:0]      nres;
        t_slot [3:0]     slots;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_qwr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

>>> hdl/pk5_in_if.sv
// ----------------------------------------------------------------------------
// pk5_in_if
// Input channel: one compressed byte or header per word.
// ----------------------------------------------------------------------------
interface pk5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_header;

    modport source (output valid, output in_byte, output is_header, input ready);
    modport sink   (input valid, input in_byte, input is_header, output ready);
endinterface

>>> hdl/pk5_out_if.sv
// ----------------------------------------------------------------------------
// pk5_out_if
// Output channel: one decoded character per word.
// ----------------------------------------------------------------------------
interface pk5_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       message_end;
    logic       overflow;
    logic       last_of_burst;

    modport source (output valid, output out_char, output message_end,
                    output overflow, output last_of_burst, input ready);
    modport sink   (input valid, input out_char, input message_end,
                    input overflow, input last_of_burst, output ready);
endinterface

>>> hdl/pk5_front.sv
// ----------------------------------------------------------------------------
// pk5_front
// Unpacks words into 5-bit codes, tracks message length and end, queues work.
// ----------------------------------------------------------------------------
module pk5_front import pk5_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pk5_in_if.sink i_in,
    input  t_qstat i_qstat,
    output t_qwr   o_qwr
);

    logic             r_active;
    logic [3:0]       r_buf;
    logic [2:0]       r_held;
    logic [CNT_W-1:0] r_cnt;

    logic [11:0] w_bits;
    logic [3:0]  w_h;
    logic [3:0]  w_h1;
    logic        w_has1;
    logic [4:0]  w_code0;
    logic [4:0]  w_code1;
    logic [2:0]  w_h2;
    logic [3:0]  w_rest;
    logic        w_acc;

    logic [CNT_W-1:0] v_cnt;
    logic [2:0]       v_n;
    logic             v_live;
    t_slot [3:0]      v_slots;

    assign w_bits  = {r_buf, i_in.in_byte};
    assign w_h     = {1'b0, r_held} + 4'd8;
    assign w_code0 = 5'(w_bits >> (w_h - 4'd5));
    assign w_h1    = w_h - 4'd5;
    assign w_has1  = (w_h1 >= 4'd5);
    assign w_code1 = 5'(w_bits >> (w_h1 - 4'd5));
    assign w_h2    = w_has1 ? 3'(w_h1 - 4'd5) : 3'(w_h1);
    assign w_rest  = 4'(w_bits & ((12'd1 << w_h2) - 12'd1));

    assign i_in.ready = !i_qstat.full;
    assign w_acc      = i_in.valid && i_in.ready;

    // Walk the one or two codes of this word; count characters, find the end.
    always_comb begin
        logic [4:0] v_code;
        logic       v_end;
        logic       v_ovf;
        v_cnt   = r_cnt;
        v_n     = '0;
        v_live  = 1'b1;
        v_slots = '0;
        v_code  = '0;
        v_end   = 1'b0;
        v_ovf   = 1'b0;
        for (int k = 0; k < 2; k++) begin
            if (v_live && (k == 0 || w_has1)) begin
                v_code = (k == 0) ? w_code0 : w_code1;
                v_cnt  = v_cnt + CNT_W'(1);
                v_end  = (v_code == CODE_END) || (v_cnt >= CNT_W'(MAX_CHARS));
                v_slots[v_n[1:0]] = '{spc: 1'b0, code: v_code, endm: v_end, ovf: 1'b0};
                v_n = v_n + 3'd1;
                if (v_end) begin
                    v_live = 1'b0;
                end else if (v_code == CODE_COMMA || v_code == CODE_PERIOD) begin
                    v_cnt = v_cnt + CNT_W'(1);
                    v_ovf = (v_cnt >= CNT_W'(MAX_CHARS));
                    v_slots[v_n[1:0]] = '{spc: 1'b1, code: v_code, endm: v_ovf, ovf: v_ovf};
                    v_n = v_n + 3'd1;
                    if (v_ovf) begin
                        v_live = 1'b0;
                    end
                end
            end
        end
    end

    // Drop data words while idle; headers always pass to set the case.
    always_comb begin
        o_qwr.push        = w_acc && (i_in.is_header || r_active);
        o_qwr.entry.hdr   = i_in.is_header;
        o_qwr.entry.cap   = ~i_in.in_byte[6];
        o_qwr.entry.nres  = i_in.is_header ? 3'd0 : v_n;
        o_qwr.entry.slots = v_slots;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_buf    <= '0;
            r_held   <= '0;
            r_cnt    <= '0;
        end else if (w_acc) begin
            if (i_in.is_header) begin
                r_active <= 1'b1;
                r_buf    <= '0;
                r_held   <= '0;
                r_cnt    <= '0;
            end else if (r_active) begin
                r_cnt <= v_cnt;
                if (v_live) begin
                    r_buf  <= w_rest;
                    r_held <= w_h2;
                end else begin
                    r_active <= 1'b0;
                    r_buf    <= '0;
                    r_held   <= '0;
                end
            end
        end
    end

endmodule

>>> hdl/pk5_queue.sv
// ----------------------------------------------------------------------------
// pk5_queue
// Short first-in first-out queue of work entries between front and back.
// ----------------------------------------------------------------------------
module pk5_queue import pk5_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qwr   i_qwr,
    input  logic   i_pop,
    output t_entry o_head,
    output t_qstat o_qstat
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    logic w_push;
    logic w_pop;

    assign o_qstat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign w_push        = i_qwr.push && !o_qstat.full;
    assign w_pop         = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_qwr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

>>> hdl/pk5_back.sv
// ----------------------------------------------------------------------------
// pk5_back
// Emits queued work one character per cycle when not stalled; capitalizes.
// ----------------------------------------------------------------------------
module pk5_back import pk5_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_head,
    input  t_qstat     i_qstat,
    output logic       o_pop,
    pk5_out_if.source  o_out
);

    logic       r_ovld;
    logic [7:0] r_char;
    logic       r_end;
    logic       r_ovf;
    logic       r_last;
    logic [1:0] r_idx;
    logic       r_cap;

    logic [1:0] n_idx;
    logic       n_cap;
    logic [7:0] n_char;

    t_slot w_slot;
    logic  w_last;
    logic  w_load;
    logic  w_emit;
    logic  w_capeff;
    logic  w_letter;

    assign w_slot   = i_head.slots[r_idx];
    assign w_last   = (({1'b0, r_idx} + 3'd1) == i_head.nres);
    assign w_load   = !r_ovld || o_out.ready;
    assign w_capeff = r_cap || (w_slot.code == CODE_CAP_SPACE);
    assign w_letter = (w_slot.code >= CODE_A) && (w_slot.code <= CODE_Z);

    always_comb begin
        n_idx  = r_idx;
        n_cap  = r_cap;
        o_pop  = 1'b0;
        w_emit = 1'b0;
        n_char = GLYPHS[w_slot.code];
        if (!i_qstat.empty) begin
            if (i_head.hdr) begin
                n_cap = i_head.cap;
                o_pop = 1'b1;
                n_idx = '0;
            end else if (w_load) begin
                w_emit = 1'b1;
                o_pop  = w_last;
                n_idx  = w_last ? 2'd0 : r_idx + 2'd1;
                if (w_slot.spc) begin
                    n_char = CHAR_SPACE;
                end else if (w_capeff && w_letter) begin
                    n_char = n_char - CASE_OFFSET;
                    n_cap  = 1'b0;
                end else begin
                    n_cap = w_capeff || (w_slot.code == CODE_PERIOD);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_idx  <= '0;
            r_cap  <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_cap <= n_cap;
            if (w_load) begin
                r_ovld <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_char <= n_char;
            r_end  <= w_slot.endm;
            r_ovf  <= w_slot.ovf;
            r_last <= w_last;
        end
    end

    assign o_out.valid         = r_ovld;
    assign o_out.out_char      = r_char;
    assign o_out.message_end   = r_end;
    assign o_out.overflow      = r_ovf;
    assign o_out.last_of_burst = r_last;

endmodule

>>> hdl/packed_5bit_text_decoder.sv
// ----------------------------------------------------------------------------
// packed_5bit_text_decoder
// Decodes 5-bit packed text messages from a byte stream into ASCII characters.
// ----------------------------------------------------------------------------
// Path: the front writes a word's unpacked codes into the queue when the word
//   is accepted; the back end reads the queue head and registers each character
//   in its output register, which drives the output.
// Throughput: the front takes one word per cycle while the 4-entry queue has
//   room; the back end gives one character per cycle unless the output stalls;
//   a data word yields one to four characters and a header word none.
// Reset: i_rst_n, synchronous, active low; clears the decoder to idle.
// ----------------------------------------------------------------------------
module packed_5bit_text_decoder import pk5_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pk5_in_if.sink     i_in,
    pk5_out_if.source  o_out
);

    // Front to queue: push request with the unpacked codes of one word.
    t_qwr   w_qwr;
    // Queue fill state, seen by both sides.
    t_qstat w_qstat;
    // Oldest queued entry and its release from the back end.
    t_entry w_head;
    logic   w_pop;

    // Front: unpack bits, count characters, decide where the message ends.
    pk5_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (w_qstat),
        .o_qwr   (w_qwr)
    );

    // Queue: decouple the word rate from the character rate.
    pk5_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (w_qwr),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    // Back end: map codes to characters, track capitalization, drive output.
    pk5_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // The front never offers work the queue cannot hold.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qwr.push |-> !w_qstat.full)
        else $error("push into full queue");

    // The back end only releases entries that exist.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty queue");

    // An overflow ends the message on an inserted space.
    a_ovf_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow) |->
            (o_out.message_end && o_out.out_char == CHAR_SPACE))
        else $error("overflow word malformed");

    // Nothing of a word follows the end of its message.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.message_end) |-> o_out.last_of_burst)
        else $error("message end not last of burst");

endmodule

>>> dv/tb_packed_5bit_text_decoder.sv
// ----------------------------------------------------------------------------
// tb_packed_5bit_text_decoder
// Self-checking bench for the packed 5-bit text decoder. Messages are packed
// into words, driven with random gaps and back-pressure, and every character
// that leaves the block is checked against an in-bench decoder.
// ----------------------------------------------------------------------------
module tb_packed_5bit_text_decoder import pk5_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes and characters that the package does not name.
    localparam logic [4:0] CODE_SPACE = 5'd0;
    localparam logic [4:0] CODE_APOS  = 5'd27;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_PERIOD  = 8'h2e;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] LOWER_BASE = 8'h60;   // one below 'a'

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    // One word on the input channel.
    typedef struct packed {
        logic [7:0] data;
        logic       hdr;
    } t_pk5_word;

    // One decoded character as it should appear on the output channel.
    typedef struct packed {
        logic [7:0] ch;
        logic       msg_end;
        logic       ovf;
        logic       burst_end;
    } t_char_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pk5_in_if  in_if();
    pk5_out_if out_if();

    packed_5bit_text_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_pk5_word   word_queue[$];     // words still to drive
    t_char_word  char_queue[$];     // characters predicted, not yet seen
    logic [4:0]  msg_codes[$];      // message under construction
    int          words_queued = 0;
    int          fail_cnt     = 0;
    int          tx_gap_pct   = 0;
    int          rx_stall_pct = 0;
    logic        in_took      = 1'b0;
    int          idle_cycles  = 0;

    // Decoder state mirrored by the bench.
    logic [11:0] bit_acc    = '0;
    logic [3:0]  acc_bits   = '0;
    logic        cap_next   = 1'b0;
    int          n_chars    = 0;
    logic        msg_active = 1'b0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [7:0] code_glyph(input logic [4:0] code);
        case (code)
            CODE_SPACE, CODE_CAP_SPACE: return CHAR_SPACE;
            CODE_APOS:                  return CH_APOS;
            CODE_COMMA:                 return CH_COMMA;
            CODE_PERIOD:                return CH_PERIOD;
            CODE_END:                   return CH_NUL;
            default:                    return LOWER_BASE + 8'(code);
        endcase
    endfunction

    // Advance the mirrored decoder by one accepted word and queue the
    // characters it must produce.
    function automatic void decode_word(input logic [7:0] data, input logic hdr);
        t_char_word burst[$];
        logic [4:0] code;
        logic [7:0] ch;
        logic       done;
        logic       ovf;
        if (hdr) begin
            // A header restarts decoding, even in mid-message.
            bit_acc    = '0;
            acc_bits   = '0;
            n_chars    = 0;
            msg_active = 1'b1;
            cap_next   = !data[6];
            return;
        end
        if (!msg_active)
            return;
        bit_acc  = {bit_acc[3:0], data};
        acc_bits = acc_bits + 4'd8;
        while (msg_active && acc_bits >= 4'd5) begin
            acc_bits = acc_bits - 4'd5;
            code     = 5'(bit_acc >> acc_bits);
            bit_acc  = bit_acc & ((12'd1 << acc_bits) - 12'd1);
            ch       = code_glyph(code);
            if (code == CODE_CAP_SPACE)
                cap_next = 1'b1;
            if (cap_next && code >= CODE_A && code <= CODE_Z) begin
                ch       = ch - CASE_OFFSET;
                cap_next = 1'b0;
            end
            n_chars++;
            done = (code == CODE_END) || (n_chars >= MAX_CHARS);
            burst.push_back('{ch, done, 1'b0, 1'b0});
            if (done) begin
                msg_active = 1'b0;
            end else if (code == CODE_COMMA || code == CODE_PERIOD) begin
                // Punctuation drags a space behind it; a space that hits the
                // limit marks the message as overrun.
                if (code == CODE_PERIOD)
                    cap_next = 1'b1;
                n_chars++;
                ovf = (n_chars >= MAX_CHARS);
                burst.push_back('{CHAR_SPACE, ovf, ovf, 1'b0});
                if (ovf)
                    msg_active = 1'b0;
            end
        end
        if (!msg_active) begin
            bit_acc  = '0;
            acc_bits = '0;
        end
        foreach (burst[i]) begin
            burst[i].burst_end = (i == burst.size() - 1);
            char_queue.push_back(burst[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------
    task automatic push_word(input logic [7:0] data, input logic hdr);
        word_queue.push_back('{data, hdr});
        words_queued++;
    endtask

    // Pack msg_codes MSB first into data words; pad the tail with random bits.
    task automatic pack_codes();
        int unsigned acc;
        int          nb;
        acc = 0;
        nb  = 0;
        foreach (msg_codes[i]) begin
            acc = ((acc << 5) | msg_codes[i]) & 32'h1fff;
            nb += 5;
            if (nb >= 8) begin
                nb -= 8;
                push_word(8'(acc >> nb), 1'b0);
                acc &= (32'd1 << nb) - 1;
            end
        end
        if (nb > 0)
            push_word(8'((acc << (8 - nb)) | $urandom_range((1 << (8 - nb)) - 1)), 1'b0);
    endtask

    function automatic logic [4:0] random_punct();
        return $urandom_range(1) ? CODE_COMMA : CODE_PERIOD;
    endfunction

    // Fill a message that runs into the character limit. With want_ovf the
    // last inserted space lands on the limit; otherwise a character does.
    task automatic build_long(input bit want_ovf);
        int         cnt;
        logic [4:0] c;
        msg_codes.delete();
        cnt = 0;
        while (cnt < MAX_CHARS - 3) begin
            c = ($urandom_range(99) < 85) ? random_punct() : 5'($urandom_range(28));
            msg_codes.push_back(c);
            cnt += (c == CODE_COMMA || c == CODE_PERIOD) ? 2 : 1;
        end
        if (want_ovf) begin
            if (cnt == MAX_CHARS - 3)
                msg_codes.push_back(5'($urandom_range(CODE_A, CODE_Z)));
            msg_codes.push_back(random_punct());
        end else if (cnt == MAX_CHARS - 3) begin
            msg_codes.push_back(random_punct());
            msg_codes.push_back(5'($urandom_range(28)));
        end else begin
            msg_codes.push_back(5'($urandom_range(CODE_A, CODE_Z)));
            msg_codes.push_back(random_punct());
        end
        push_word(8'($urandom_range(255)), 1'b1);
        pack_codes();
        // Words past the end are dropped by the block.
        push_word(8'($urandom_range(255)), 1'b0);
    endtask

    // Mostly short well-formed messages, some cut short, some stray words.
    task automatic random_message();
        int n;
        if ($urandom_range(99) < 8) begin
            push_word(8'($urandom_range(255)), 1'b0);
            return;
        end
        push_word(8'($urandom_range(255)), 1'b1);
        msg_codes.delete();
        n = $urandom_range(1, 10);
        repeat (n) begin
            if ($urandom_range(99) < 20)
                msg_codes.push_back(random_punct());
            else
                msg_codes.push_back(5'($urandom_range(30)));
        end
        if ($urandom_range(99) < 85)
            msg_codes.push_back(CODE_END);
        pack_codes();
    endtask

    task automatic wait_words_sent();
        while (word_queue.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: launch words and toggle back-pressure on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_words
        t_pk5_word w;
        out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.in_byte   <= '0;
            in_if.is_header <= 1'b0;
        end else if (!in_if.valid || in_took) begin
            // Previous word gone (or none held): load the next one or idle.
            if (word_queue.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin
                w = word_queue.pop_front();
                in_if.valid     <= 1'b1;
                in_if.in_byte   <= w.data;
                in_if.is_header <= w.hdr;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_channels
        t_char_word exp_c;
        in_took <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n) begin
            // Check outputs first; a word accepted on this edge cannot have
            // produced anything yet.
            if (out_if.valid && out_if.ready) begin
                if (char_queue.size() == 0) begin
                    $display("%0t: unexpected char %02h end=%0b ovf=%0b last=%0b", $time,
                             out_if.out_char, out_if.message_end, out_if.overflow,
                             out_if.last_of_burst);
                    fail_cnt++;
                end else begin
                    exp_c = char_queue.pop_front();
                    if (out_if.out_char !== exp_c.ch) begin
                        $display("%0t: out_char expected %02h actual %02h", $time,
                                 exp_c.ch, out_if.out_char);
                        fail_cnt++;
                    end
                    if (out_if.message_end !== exp_c.msg_end) begin
                        $display("%0t: message_end expected %0b actual %0b", $time,
                                 exp_c.msg_end, out_if.message_end);
                        fail_cnt++;
                    end
                    if (out_if.overflow !== exp_c.ovf) begin
                        $display("%0t: overflow expected %0b actual %0b", $time,
                                 exp_c.ovf, out_if.overflow);
                        fail_cnt++;
                    end
                    if (out_if.last_of_burst !== exp_c.burst_end) begin
                        $display("%0t: last_of_burst expected %0b actual %0b", $time,
                                 exp_c.burst_end, out_if.last_of_burst);
                        fail_cnt++;
                    end
                end
            end
            if (in_if.valid && in_if.ready)
                decode_word(in_if.in_byte, in_if.is_header);
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sparse sender gaps, heavy back-pressure.
        tx_gap_pct   = 19;
        rx_stall_pct = 77;

        // Directed: a data word while idle is dropped.
        push_word(8'hff, 1'b0);
        // Capitalized start, then space, a, z, apostrophe, capitalizing
        // space, comma, period and the end code.
        push_word(8'hbf, 1'b1);
        msg_codes = '{CODE_SPACE, CODE_A, CODE_Z, CODE_APOS, CODE_CAP_SPACE, 5'd2,
                      CODE_COMMA, 5'd3, CODE_PERIOD, 5'd4, CODE_SPACE, 5'd5, CODE_END};
        pack_codes();
        // Lower-case start abandoned by a second header in mid-message.
        push_word(8'h40, 1'b1);
        push_word(8'h00, 1'b0);
        push_word(8'h7f, 1'b1);
        // All ones: end code straight away, rest of the word dropped.
        push_word(8'hff, 1'b0);
        push_word(8'h00, 1'b0);

        while (words_queued < 30)
            random_message();
        build_long(1'b1);
        wait_words_sent();

        // Phase two: heavy sender gaps, light back-pressure.
        tx_gap_pct   = 77;
        rx_stall_pct = 19;
        while (words_queued < 135)
            random_message();
        build_long(1'b0);
        wait_words_sent();

        // Phase three: full rate both ways.
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        while (words_queued < 230)
            random_message();

        // Hold until the last word is taken and every character is back.
        while (word_queue.size() != 0 || in_if.valid)
            @(posedge i_clk);
        while (char_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
